// File: hdl/rmfu_pkg.sv
// ---------------------------------------------------------------------------
// rmfu_pkg: shared types and constants for the relation matrix function unit
// Holds the symbol sizes, the command codes and the word types that the
// datapath and the top level exchange.
// ---------------------------------------------------------------------------
package rmfu_pkg;

    // Relation geometry: SYMBOLS x SYMBOLS bits over 4-bit symbols
    localparam int SYMBOLS = 16;
    localparam int SYM_W   = 4;
    localparam int MAP_W   = SYMBOLS * SYM_W;

    typedef logic [SYM_W-1:0]   sym_t;
    typedef logic [SYMBOLS-1:0] row_t;
    typedef row_t [SYMBOLS-1:0] rows_t;
    typedef logic [MAP_W-1:0]   map_t;

    // Command codes
    typedef enum logic [3:0] {
        CMD_WRROW     = 4'd0,
        CMD_WRCOL     = 4'd1,
        CMD_WRBIT     = 4'd2,
        CMD_RDROW     = 4'd3,
        CMD_RDCOL     = 4'd4,
        CMD_RDBIT     = 4'd5,
        CMD_CLEAR     = 4'd6,
        CMD_FILL      = 4'd7,
        CMD_IDENT     = 4'd8,
        CMD_SINGLETON = 4'd9,
        CMD_PREMUL    = 4'd10,
        CMD_PREDIV    = 4'd11,
        CMD_POSTMUL   = 4'd12,
        CMD_POSTDIV   = 4'd13,
        CMD_TRANSPOSE = 4'd14,
        CMD_CONTAINS  = 4'd15
    } cmd_t;

    // One input word as held in the input register
    typedef struct packed {
        cmd_t  command;
        sym_t  row_index;
        sym_t  column_index;
        row_t  slice_data;
        logic  bit_value;
        map_t  fn_map;
    } item_t;

    // One result word
    typedef struct packed {
        row_t  read_data;
        logic  contains_flag;
    } result_t;

endpackage

// File: hdl/rmfu_core.sv
// ---------------------------------------------------------------------------
// rmfu_core: single-pass relation datapath
// Combinational: from the current relation and one held word, forms the
// next relation and the result word.
// ---------------------------------------------------------------------------
module rmfu_core (
    input  rmfu_pkg::rows_t   rows,
    input  rmfu_pkg::item_t   item,
    output rmfu_pkg::rows_t   rows_next,
    output rmfu_pkg::result_t result
);
    import rmfu_pkg::*;

    // map entries f(i), unpacked from the nibbles
    sym_t fmap [SYMBOLS];

    always_comb
    begin
        for (int i = 0; i < SYMBOLS; i++)
        begin
            fmap[i] = item.fn_map[i*SYM_W +: SYM_W];
        end
    end

    // next relation and result
    always_comb
    begin
        row_t acc;
        logic flag;

        rows_next            = rows;
        result.read_data     = '0;
        result.contains_flag = 1'b0;
        acc                  = '0;
        flag                 = 1'b1;

        case (item.command)
            CMD_WRROW:
            begin
                rows_next[item.row_index] = item.slice_data;
            end
            CMD_WRCOL:
            begin
                for (int i = 0; i < SYMBOLS; i++)
                begin
                    rows_next[i][item.column_index] = item.slice_data[i];
                end
            end
            CMD_WRBIT:
            begin
                rows_next[item.row_index][item.column_index] = item.bit_value;
            end
            CMD_RDROW:
            begin
                result.read_data = rows[item.row_index];
            end
            CMD_RDCOL:
            begin
                for (int i = 0; i < SYMBOLS; i++)
                begin
                    acc[i] = rows[i][item.column_index];
                end
                result.read_data = acc;
            end
            CMD_RDBIT:
            begin
                result.read_data = {{(SYMBOLS-1){1'b0}}, rows[item.row_index][item.column_index]};
            end
            CMD_CLEAR:
            begin
                rows_next = '0;
            end
            CMD_FILL:
            begin
                rows_next = '1;
            end
            CMD_IDENT:
            begin
                for (int i = 0; i < SYMBOLS; i++)
                begin
                    rows_next[i]    = '0;
                    rows_next[i][i] = 1'b1;
                end
            end
            CMD_SINGLETON:
            begin
                for (int i = 0; i < SYMBOLS; i++)
                begin
                    rows_next[i]          = '0;
                    rows_next[i][fmap[i]] = 1'b1;
                end
            end
            CMD_PREMUL:
            begin
                for (int i = 0; i < SYMBOLS; i++)
                begin
                    rows_next[i] = rows[fmap[i]];
                end
            end
            CMD_PREDIV:
            begin
                // row j: AND of every row i that f sends to j, ones if none
                for (int j = 0; j < SYMBOLS; j++)
                begin
                    rows_next[j] = '1;
                    for (int i = 0; i < SYMBOLS; i++)
                    begin
                        if (fmap[i] == SYM_W'(j))
                        begin
                            rows_next[j] = rows_next[j] & rows[i];
                        end
                    end
                end
            end
            CMD_POSTMUL:
            begin
                // column f(o) collects column o
                for (int r = 0; r < SYMBOLS; r++)
                begin
                    rows_next[r] = '0;
                    for (int o = 0; o < SYMBOLS; o++)
                    begin
                        if (rows[r][o])
                        begin
                            rows_next[r][fmap[o]] = 1'b1;
                        end
                    end
                end
            end
            CMD_POSTDIV:
            begin
                for (int r = 0; r < SYMBOLS; r++)
                begin
                    for (int o = 0; o < SYMBOLS; o++)
                    begin
                        rows_next[r][o] = rows[r][fmap[o]];
                    end
                end
            end
            CMD_TRANSPOSE:
            begin
                for (int r = 0; r < SYMBOLS; r++)
                begin
                    for (int o = 0; o < SYMBOLS; o++)
                    begin
                        rows_next[r][o] = rows[o][r];
                    end
                end
            end
            CMD_CONTAINS:
            begin
                for (int i = 0; i < SYMBOLS; i++)
                begin
                    flag = flag & rows[i][fmap[i]];
                end
                result.contains_flag = flag;
            end
            default:
            begin
                rows_next = rows;
            end
        endcase
    end

endmodule

// File: hdl/relation_matrix_function_unit_top.sv
// An accepted word is held in the input register, and its result word moves
// to the result register once the output is not stalled.
// Throughput: one word per cycle unless the output stalls; input register,
// single-pass relation datapath and result register form a two-stage pipeline.
// Reset (rst_n low, asynchronous): relation cleared to the empty relation,
// both pipeline stages empty.
// ---------------------------------------------------------------------------
// relation_matrix_function_unit_top: 16x16 relation unit
// Input register, relation store with one-pass update, result register.
// ---------------------------------------------------------------------------
module relation_matrix_function_unit_top (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [3:0]            command,
    input  rmfu_pkg::sym_t        row_index,
    input  rmfu_pkg::sym_t        column_index,
    input  rmfu_pkg::row_t        slice_data,
    input  logic                  bit_value,
    input  rmfu_pkg::map_t        fn_map,
    output logic                  out_valid,
    input  logic                  out_ready,
    output rmfu_pkg::row_t        read_data,
    output logic                  contains_flag
);
    import rmfu_pkg::*;

    logic    s1_valid_reg;
    item_t   s1_item_reg;
    rows_t   rows_reg;
    rows_t   rows_next;
    result_t result_next;
    result_t out_data_reg;
    logic    out_valid_reg;
    logic    advance;

    // stage handshake
    assign advance  = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !s1_valid_reg || advance;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            s1_item_reg <= '{command:      cmd_t'(command),
                             row_index:    row_index,
                             column_index: column_index,
                             slice_data:   slice_data,
                             bit_value:    bit_value,
                             fn_map:       fn_map};
        end
    end

    // datapath
    rmfu_core u_core (
        .rows      (rows_reg),
        .item      (s1_item_reg),
        .rows_next (rows_next),
        .result    (result_next)
    );

    // relation store
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_reg <= '0;
        end
        else if (advance)
        begin
            rows_reg <= rows_next;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_data_reg <= result_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign read_data     = out_data_reg.read_data;
    assign contains_flag = out_data_reg.contains_flag;

    // checks
    a_flag_excl: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(out_data_reg.contains_flag && (out_data_reg.read_data != '0)))
        else $error("contains flag and read data both set");

    a_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && (s1_item_reg.command == CMD_CLEAR)) |=> (rows_reg == '0))
        else $error("relation not empty after clear");

    a_fill: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && (s1_item_reg.command == CMD_FILL)) |=> (rows_reg == '1))
        else $error("relation not full after fill");

    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !s1_valid_reg |-> in_ready)
        else $error("input blocked with empty stage");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !advance) |=> $stable(rows_reg))
        else $error("relation changed while stage stalled");

endmodule

// File: verif/tb_top.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_top: self-checking bench for the relation matrix function unit
// Drives command words over a valid/ready channel and keeps its own copy of
// the 16x16 relation. Every accepted word is predicted, and each returned
// word is checked in order. The run covers directed corner cases, random
// traffic under several idling mixes and a long output stall.
// ---------------------------------------------------------------------------
module tb_top;

    import rmfu_pkg::*;

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_ready;
    logic [3:0] command;
    sym_t       row_index;
    sym_t       column_index;
    row_t       slice_data;
    logic       bit_value;
    map_t       fn_map;
    logic       out_valid;
    logic       out_ready;
    row_t       read_data;
    logic       contains_flag;

    // Local copy of the relation and the words still owed by the block
    rows_t      relation_model;
    result_t    expected_results[$];
    int         error_count     = 0;
    int         results_checked = 0;
    int         contains_hits   = 0;

    // Idling mix, in percent per cycle, and the long output hold-off
    int         send_idle_pct   = 0;
    int         recv_stall_pct  = 0;
    int         hold_cycles     = 0;
    map_t       recent_map      = '0;

    relation_matrix_function_unit_top dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .command       (command),
        .row_index     (row_index),
        .column_index  (column_index),
        .slice_data    (slice_data),
        .bit_value     (bit_value),
        .fn_map        (fn_map),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .read_data     (read_data),
        .contains_flag (contains_flag)
    );

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Run limit
    initial
    begin
        #2000000;
        $display("tb_top: done, errors");
        $finish;
    end

    // Apply one command word to the local relation and return its result
    function automatic result_t apply_word(input item_t w);
        rows_t   nxt;
        result_t res;
        row_t    acc;
        sym_t    j;
        nxt = relation_model;
        res = '0;
        case (w.command)
            CMD_WRROW:
                nxt[w.row_index] = w.slice_data;
            CMD_WRCOL:
                for (int i = 0; i < SYMBOLS; i++)
                    nxt[i][w.column_index] = w.slice_data[i];
            CMD_WRBIT:
                nxt[w.row_index][w.column_index] = w.bit_value;
            CMD_RDROW:
                res.read_data = relation_model[w.row_index];
            CMD_RDCOL:
                for (int i = 0; i < SYMBOLS; i++)
                    res.read_data[i] = relation_model[i][w.column_index];
            CMD_RDBIT:
                res.read_data[0] = relation_model[w.row_index][w.column_index];
            CMD_CLEAR:
                nxt = '0;
            CMD_FILL:
                nxt = '1;
            CMD_IDENT:
                for (int i = 0; i < SYMBOLS; i++)
                    nxt[i] = row_t'(1) << i;
            CMD_SINGLETON:
                for (int i = 0; i < SYMBOLS; i++)
                    nxt[i] = row_t'(1) << w.fn_map[i*SYM_W +: SYM_W];
            CMD_PREMUL:
                for (int i = 0; i < SYMBOLS; i++)
                    nxt[i] = relation_model[w.fn_map[i*SYM_W +: SYM_W]];
            CMD_PREDIV:
            begin
                // rows nobody maps to stay all ones
                nxt = '1;
                for (int i = 0; i < SYMBOLS; i++)
                begin
                    j = w.fn_map[i*SYM_W +: SYM_W];
                    nxt[j] = nxt[j] & relation_model[i];
                end
            end
            CMD_POSTMUL:
                for (int i = 0; i < SYMBOLS; i++)
                begin
                    acc = '0;
                    for (int o = 0; o < SYMBOLS; o++)
                        acc[w.fn_map[o*SYM_W +: SYM_W]] |= relation_model[i][o];
                    nxt[i] = acc;
                end
            CMD_POSTDIV:
                for (int i = 0; i < SYMBOLS; i++)
                    for (int o = 0; o < SYMBOLS; o++)
                        nxt[i][o] = relation_model[i][w.fn_map[o*SYM_W +: SYM_W]];
            CMD_TRANSPOSE:
                for (int i = 0; i < SYMBOLS; i++)
                    for (int o = 0; o < SYMBOLS; o++)
                        nxt[i][o] = relation_model[o][i];
            CMD_CONTAINS:
            begin
                res.contains_flag = 1'b1;
                for (int i = 0; i < SYMBOLS; i++)
                    if (!relation_model[i][w.fn_map[i*SYM_W +: SYM_W]])
                        res.contains_flag = 1'b0;
            end
            default:
                res = '0;
        endcase
        relation_model = nxt;
        return res;
    endfunction

    // Check returned words first, then record the word taken at this edge
    always @(posedge clk)
    begin : result_check
        item_t   taken;
        result_t want;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                results_checked++;
                if (expected_results.size() == 0)
                begin
                    error_count++;
                    $display("%0t: unexpected word, got read_data %h flag %b",
                             $time, read_data, contains_flag);
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (read_data !== want.read_data)
                    begin
                        error_count++;
                        $display("%0t: read_data mismatch, expected %h, got %h",
                                 $time, want.read_data, read_data);
                    end
                    if (contains_flag !== want.contains_flag)
                    begin
                        error_count++;
                        $display("%0t: contains_flag mismatch, expected %b, got %b",
                                 $time, want.contains_flag, contains_flag);
                    end
                end
            end
            if (in_valid && in_ready)
            begin
                taken.command      = cmd_t'(command);
                taken.row_index    = row_index;
                taken.column_index = column_index;
                taken.slice_data   = slice_data;
                taken.bit_value    = bit_value;
                taken.fn_map       = fn_map;
                if (taken.command == CMD_CONTAINS)
                    contains_hits++;
                expected_results.push_back(apply_word(taken));
            end
        end
    end

    // Output side: random stalls, or a counted hold-off when requested
    initial
    begin
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_cycles > 0)
            begin
                out_ready = 1'b0;
                hold_cycles--;
            end
            else
                out_ready = ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // Offer one word and hold it until taken
    task automatic send_word(input cmd_t cmd, input sym_t r, input sym_t c,
                             input row_t d, input logic b, input map_t f);
        @(negedge clk);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        command      = cmd;
        row_index    = r;
        column_index = c;
        slice_data   = d;
        bit_value    = b;
        fn_map       = f;
        in_valid     = 1'b1;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    // Drop valid and wait until every owed word is back
    task automatic wait_for_results();
        @(negedge clk);
        in_valid = 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
    endtask

    // One random word: mostly accesses, with map transforms and tests mixed in
    task automatic send_random_word();
        int   pick;
        cmd_t cmd;
        map_t f;
        pick = $urandom_range(0, 99);
        if (pick < 12)
            cmd = CMD_WRROW;
        else if (pick < 20)
            cmd = CMD_WRCOL;
        else if (pick < 28)
            cmd = CMD_WRBIT;
        else if (pick < 40)
            cmd = CMD_RDROW;
        else if (pick < 48)
            cmd = CMD_RDCOL;
        else if (pick < 56)
            cmd = CMD_RDBIT;
        else if (pick < 63)
            cmd = cmd_t'($urandom_range(CMD_CLEAR, CMD_SINGLETON));
        else if (pick < 88)
            cmd = cmd_t'($urandom_range(CMD_PREMUL, CMD_TRANSPOSE));
        else
            cmd = CMD_CONTAINS;
        f = {$urandom, $urandom};
        if (cmd == CMD_SINGLETON)
            recent_map = f;
        // reuse the last singleton map so containment is often true
        if (cmd == CMD_CONTAINS && $urandom_range(0, 1))
            f = recent_map;
        send_word(cmd, sym_t'($urandom_range(0, 15)), sym_t'($urandom_range(0, 15)),
                  row_t'($urandom_range(0, 65535)), 1'($urandom_range(0, 1)), f);
    endtask

    task automatic run_random(input int count, input int s_pct, input int r_pct);
        send_idle_pct  = s_pct;
        recv_stall_pct = r_pct;
        repeat (count)
            send_random_word();
        wait_for_results();
    endtask

    // Edge values of every field and each command at least once
    task automatic test_directed_cases();
        send_word(CMD_WRROW,     0,  0, 16'hFFFF, 0, '0);
        send_word(CMD_WRROW,    15,  3, 16'h8001, 1, '1);
        send_word(CMD_RDROW,     0, 15, 16'h0000, 0, '0);
        send_word(CMD_RDROW,    15,  0, 16'hFFFF, 1, '1);
        send_word(CMD_WRCOL,     4, 15, 16'hA5A5, 0, '0);
        send_word(CMD_WRCOL,     9,  0, 16'hFFFF, 1, '0);
        send_word(CMD_RDCOL,     0, 15, 16'h0000, 0, '0);
        send_word(CMD_RDCOL,    15,  0, 16'h0000, 0, '0);
        send_word(CMD_WRBIT,    15,  0, 16'h0000, 0, '0);
        send_word(CMD_WRBIT,     7,  8, 16'h0000, 1, '0);
        send_word(CMD_RDBIT,    15,  0, 16'h0000, 0, '0);
        // all-to-zero map over a column with one hole
        send_word(CMD_CONTAINS,  0,  0, 16'h0000, 0, 64'h0);
        send_word(CMD_FILL,      0,  0, 16'h0000, 0, '0);
        send_word(CMD_CONTAINS,  0,  0, 16'h0000, 0, '1);
        send_word(CMD_IDENT,     0,  0, 16'h0000, 0, '0);
        send_word(CMD_CONTAINS,  0,  0, 16'h0000, 0, 64'hFEDC_BA98_7654_3210);
        send_word(CMD_PREMUL,    0,  0, 16'h0000, 0, 64'h0123_4567_89AB_CDEF);
        send_word(CMD_POSTDIV,   0,  0, 16'h0000, 0, '1);
        send_word(CMD_SINGLETON, 0,  0, 16'h0000, 0, 64'h5A3C_F096_1E87_D24B);
        send_word(CMD_POSTMUL,   0,  0, 16'h0000, 0, 64'h0000_1111_2222_FFFF);
        // every row maps to zero, rows 1 to 15 get no preimage
        send_word(CMD_PREDIV,    0,  0, 16'h0000, 0, 64'h0);
        send_word(CMD_TRANSPOSE, 0,  0, 16'h0000, 0, '0);
        send_word(CMD_RDCOL,     0, 15, 16'h0000, 0, '0);
        send_word(CMD_CLEAR,     0,  0, 16'h0000, 0, '1);
        send_word(CMD_RDROW,     8,  0, 16'h0000, 0, '0);
        wait_for_results();
    endtask

    task automatic test_steady_stream();
        run_random(320, 0, 0);
    endtask

    task automatic test_sparse_input();
        run_random(320, 61, 0);
    endtask

    task automatic test_slow_output();
        run_random(320, 0, 61);
    endtask

    task automatic test_mixed_idling();
        run_random(320, 30, 30);
    endtask

    // Output held off long enough for the pipeline to fill and stall input
    task automatic test_full_pipeline();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_cycles    = 160;
        repeat (60)
            send_random_word();
        wait_for_results();
    endtask

    task automatic test_wrap_up();
        run_random(180, 30, 30);
    endtask

    // Sequence
    initial
    begin
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        command        = CMD_WRROW;
        row_index      = '0;
        column_index   = '0;
        slice_data     = '0;
        bit_value      = 1'b0;
        fn_map         = '0;
        relation_model = '0;
        repeat (7)
            @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed_cases();
        test_steady_stream();
        test_sparse_input();
        test_slow_output();
        test_mixed_idling();
        test_full_pipeline();
        test_wrap_up();

        // let any stray word show up
        repeat (10)
            @(posedge clk);

        $display("tb_top: %0d words checked, %0d containment tests", results_checked,
                 contains_hits);
        $display("tb_top: covered corner cases, four idling mixes and a long output stall");
        if (error_count == 0)
            $display("tb_top: done, clean");
        else
            $display("tb_top: done, errors");
        $finish;
    end

endmodule

// File: sim.f
hdl/rmfu_pkg.sv
hdl/rmfu_core.sv
hdl/relation_matrix_function_unit_top.sv
verif/tb_top.sv
